// ===== rtl/core/isp_pkg.sv =====
// Shared types, constants and helper functions of the iSLIP strict-priority scheduler.
`timescale 1ns / 1ps
package isp_pkg;

  // Port and priority counts
  localparam int unsigned NUM_INPUTS     = 4;
  localparam int unsigned NUM_OUTPUTS    = 4;
  localparam int unsigned NUM_PRIORITIES = 4;

  // Derived widths
  localparam int unsigned IW = $clog2(NUM_INPUTS);
  localparam int unsigned OW = $clog2(NUM_OUTPUTS);
  localparam int unsigned PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int unsigned XW = (IW > OW) ? IW : OW;
  localparam int unsigned NQ = NUM_INPUTS * NUM_OUTPUTS * NUM_PRIORITIES;
  localparam int unsigned QW = $clog2(NQ);
  localparam int unsigned CW = 8;

  // Fixed field widths
  localparam int unsigned FW   = 2;
  localparam int unsigned ITW  = 3;
  localparam int unsigned CIXW = 1;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_ARBITRATE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_MATCH   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [CIXW-1:0] {
    REG_ITERATION_COUNT = 1'b0,
    REG_QUEUE_LIMIT     = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_GRANT,
    S_ACCEPT,
    S_DEC,
    S_EMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t         status;
    logic [FW-1:0]   match_input;
    logic [FW-1:0]   match_output;
    logic [FW-1:0]   match_priority;
    logic            last;
  } result_t;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] idx;
  } pick_in_t;

  typedef struct packed {
    logic          found;
    logic [OW-1:0] idx;
  } pick_out_t;

  // Flat index of one virtual output queue counter
  function automatic logic [QW-1:0] qidx(input int unsigned i, input int unsigned o,
                                         input int unsigned p);
    return QW'((i * NUM_OUTPUTS + o) * NUM_PRIORITIES + p);
  endfunction

  // Round-robin pick over inputs, first requester at or after start
  function automatic pick_in_t rr_pick_in(input logic [NUM_INPUTS-1:0] req,
                                          input logic [IW-1:0] start);
    pick_in_t r;
    int unsigned k;
    r = '0;
    for (int s = NUM_INPUTS - 1; s >= 0; s--) begin
      k = int'(start) + s;
      if (k >= NUM_INPUTS) k = k - NUM_INPUTS;
      if (req[k]) begin
        r.found = 1'b1;
        r.idx   = IW'(k);
      end
    end
    return r;
  endfunction

  // Round-robin pick over outputs, first requester at or after start
  function automatic pick_out_t rr_pick_out(input logic [NUM_OUTPUTS-1:0] req,
                                            input logic [OW-1:0] start);
    pick_out_t r;
    int unsigned k;
    r = '0;
    for (int s = NUM_OUTPUTS - 1; s >= 0; s--) begin
      k = int'(start) + s;
      if (k >= NUM_OUTPUTS) k = k - NUM_OUTPUTS;
      if (req[k]) begin
        r.found = 1'b1;
        r.idx   = OW'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/isp_if.sv =====
// Channel interfaces of the scheduler: command input, result output, register writes.
`timescale 1ns / 1ps
interface isp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] in_port;
  logic [1:0] out_port;
  logic [1:0] priority_req;
  modport source (output valid, command, in_port, out_port, priority_req, input ready);
  modport sink (input valid, command, in_port, out_port, priority_req, output ready);
endinterface

interface isp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] match_input;
  logic [1:0] match_output;
  logic [1:0] match_priority;
  logic       last;
  modport source (output valid, status, match_input, match_output, match_priority, last,
                  input ready);
  modport sink (input valid, status, match_input, match_output, match_priority, last,
                output ready);
endinterface

interface isp_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/islip_strict_priority_scheduler.sv =====
// Top level: iSLIP crossbar scheduler with strict-priority VOQ counters.
// Enqueue: the result is registered from S_ENQ; the next input is taken once back in S_IDLE.
// Arbitrate: per iteration the outputs are walked in S_GRANT and the inputs in S_ACCEPT,
//   with S_DEC and S_EMIT per match, then S_FINISH and S_IDLE before the next input transfer.
// A full result register stalls enqueue, finish and, with a match pending, emit until it drains.
// Synchronous active-low reset clears pointers, nonempty flags and control, sets config defaults only.
`timescale 1ns / 1ps
module islip_strict_priority_scheduler (
  input  logic      clk,
  input  logic      rst_n,
  isp_in_if.sink    in_ch,
  isp_out_if.source out_ch,
  isp_cfg_if.sink   cfg_ch
);
  import isp_pkg::*;

  state_t state_r, state_nxt;
  logic [XW-1:0] cnt_r, cnt_nxt;
  logic [ITW-1:0] it_r, it_nxt;
  logic [ITW-1:0] iter_cnt_r;
  logic [CW-1:0] limit_r;
  logic [NUM_INPUTS-1:0] in_busy_r, in_busy_nxt;
  logic [NUM_OUTPUTS-1:0] out_busy_r, out_busy_nxt;
  logic [NUM_OUTPUTS-1:0] gv_r, gv_nxt;
  logic [IW-1:0] gnt_r [NUM_OUTPUTS];
  logic [IW-1:0] gnt_nxt [NUM_OUTPUTS];
  logic [IW-1:0] gptr_r [NUM_OUTPUTS];
  logic [IW-1:0] gptr_nxt [NUM_OUTPUTS];
  logic [OW-1:0] aptr_r [NUM_INPUTS];
  logic [OW-1:0] aptr_nxt [NUM_INPUTS];
  logic [NQ-1:0] nz_r, nz_nxt;
  logic [QW-1:0] q_r, q_nxt, rd_addr;
  logic [CW-1:0] rd_r;
  logic [CW-1:0] mem [NQ];
  logic mem_we;
  logic [CW-1:0] mem_wd;
  logic [FW-1:0] eq_in_r, eq_in_nxt, eq_out_r, eq_out_nxt, eq_pr_r, eq_pr_nxt;
  logic [IW-1:0] mi_r, mi_nxt;
  logic [OW-1:0] mo_r, mo_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic pend_v_r, pend_v_nxt;
  result_t pend_r, pend_nxt;
  logic out_v_r, out_v_nxt;
  result_t out_r, out_nxt;

  // Combinational helpers
  logic can_emit;
  logic [OW-1:0] cur_o;
  logic [IW-1:0] cur_i;
  logic [NUM_INPUTS-1:0] g_req, g_best;
  logic [NUM_OUTPUTS-1:0] a_req;
  pick_in_t g_pick;
  pick_out_t a_pick;
  logic [PW-1:0] sel_p;
  logic [CW-1:0] cur_cnt;
  logic in_range;
  state_t adv_state;
  logic [XW-1:0] adv_cnt;
  logic [ITW-1:0] adv_it;

  assign can_emit = !out_v_r || out_ch.ready;
  assign cur_o = cnt_r[OW-1:0];
  assign cur_i = cnt_r[IW-1:0];
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.status = out_r.status;
  assign out_ch.match_input = out_r.match_input;
  assign out_ch.match_output = out_r.match_output;
  assign out_ch.match_priority = out_r.match_priority;
  assign out_ch.last = out_r.last;

  // Grant side: lowest nonempty priority among free inputs, then round robin
  always_comb begin
    g_best = '0;
    for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        g_req[i] = nz_r[qidx(i, cur_o, p)] & !in_busy_r[i];
      end
      if (|g_req) g_best = g_req;
    end
    g_pick = rr_pick_in(g_best, gptr_r[cur_o]);
  end

  // Accept side: granting free outputs, round robin from accept pointer
  always_comb begin
    for (int o = 0; o < NUM_OUTPUTS; o++) begin
      a_req[o] = gv_r[o] && (gnt_r[o] == cur_i) && !out_busy_r[o];
    end
    a_pick = rr_pick_out(a_req, aptr_r[cur_i]);
    sel_p = '0;
    for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
      if (nz_r[qidx(cur_i, a_pick.idx, p)]) sel_p = PW'(p);
    end
  end

  // Step to next input, next iteration or finish
  always_comb begin
    adv_state = S_ACCEPT;
    adv_cnt = cnt_r + XW'(1);
    adv_it = it_r;
    if (cur_i == IW'(NUM_INPUTS - 1)) begin
      adv_cnt = '0;
      if (it_r + ITW'(1) == iter_cnt_r) begin
        adv_state = S_FINISH;
      end else begin
        adv_state = S_GRANT;
        adv_it = it_r + ITW'(1);
      end
    end
  end

  assign cur_cnt = nz_r[q_r] ? rd_r : '0;
  assign in_range = (3'(eq_in_r) < 3'(NUM_INPUTS)) && (3'(eq_out_r) < 3'(NUM_OUTPUTS)) &&
                    (3'(eq_pr_r) < 3'(NUM_PRIORITIES));

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    it_nxt = it_r;
    in_busy_nxt = in_busy_r;
    out_busy_nxt = out_busy_r;
    gv_nxt = gv_r;
    gnt_nxt = gnt_r;
    gptr_nxt = gptr_r;
    aptr_nxt = aptr_r;
    nz_nxt = nz_r;
    q_nxt = q_r;
    rd_addr = q_r;
    mem_we = 1'b0;
    mem_wd = '0;
    eq_in_nxt = eq_in_r;
    eq_out_nxt = eq_out_r;
    eq_pr_nxt = eq_pr_r;
    mi_nxt = mi_r;
    mo_nxt = mo_r;
    sp_nxt = sp_r;
    pend_v_nxt = pend_v_r;
    pend_nxt = pend_r;
    out_v_nxt = out_v_r;
    out_nxt = out_r;
    if (out_v_r && out_ch.ready) out_v_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == CMD_ARBITRATE) begin
            in_busy_nxt = '0;
            out_busy_nxt = '0;
            gv_nxt = '0;
            it_nxt = '0;
            cnt_nxt = '0;
            pend_v_nxt = 1'b0;
            state_nxt = (iter_cnt_r == '0) ? S_FINISH : S_GRANT;
          end else begin
            eq_in_nxt = in_ch.in_port;
            eq_out_nxt = in_ch.out_port;
            eq_pr_nxt = in_ch.priority_req;
            q_nxt = qidx(in_ch.in_port, in_ch.out_port, in_ch.priority_req);
            rd_addr = q_nxt;
            state_nxt = S_ENQ;
          end
        end
      end
      S_ENQ: begin
        if (can_emit) begin
          out_v_nxt = 1'b1;
          out_nxt = '{ST_DROPPED, eq_in_r, eq_out_r, eq_pr_r, 1'b1};
          if (in_range && cur_cnt < limit_r) begin
            mem_we = 1'b1;
            mem_wd = cur_cnt + CW'(1);
            nz_nxt[q_r] = 1'b1;
            out_nxt.status = ST_QUEUED;
          end
          state_nxt = S_IDLE;
        end
      end
      S_GRANT: begin
        gv_nxt[cur_o] = 1'b0;
        if (!out_busy_r[cur_o] && g_pick.found) begin
          gv_nxt[cur_o] = 1'b1;
          gnt_nxt[cur_o] = g_pick.idx;
        end
        cnt_nxt = cnt_r + XW'(1);
        if (cur_o == OW'(NUM_OUTPUTS - 1)) begin
          cnt_nxt = '0;
          state_nxt = S_ACCEPT;
        end
      end
      S_ACCEPT: begin
        if (!in_busy_r[cur_i] && a_pick.found) begin
          in_busy_nxt[cur_i] = 1'b1;
          out_busy_nxt[a_pick.idx] = 1'b1;
          if (it_r == '0) begin
            gptr_nxt[a_pick.idx] = (cur_i == IW'(NUM_INPUTS - 1)) ? '0 : cur_i + IW'(1);
            aptr_nxt[cur_i] = (a_pick.idx == OW'(NUM_OUTPUTS - 1)) ? '0 :
                              a_pick.idx + OW'(1);
          end
          mi_nxt = cur_i;
          mo_nxt = a_pick.idx;
          sp_nxt = sel_p;
          q_nxt = qidx(cur_i, a_pick.idx, sel_p);
          rd_addr = q_nxt;
          state_nxt = S_DEC;
        end else begin
          state_nxt = adv_state;
          cnt_nxt = adv_cnt;
          it_nxt = adv_it;
        end
      end
      S_DEC: begin
        mem_we = 1'b1;
        mem_wd = rd_r - CW'(1);
        if (rd_r == CW'(1)) nz_nxt[q_r] = 1'b0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!pend_v_r || can_emit) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt = pend_r;
            out_nxt.last = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_nxt = '{ST_MATCH, FW'(mi_r), FW'(mo_r), FW'(sp_r), 1'b1};
          state_nxt = adv_state;
          cnt_nxt = adv_cnt;
          it_nxt = adv_it;
        end
      end
      S_FINISH: begin
        if (can_emit) begin
          out_v_nxt = 1'b1;
          out_nxt = pend_v_r ? pend_r : '{ST_NOMATCH, '0, '0, '0, 1'b1};
          pend_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      it_r <= '0;
      in_busy_r <= '0;
      out_busy_r <= '0;
      gv_r <= '0;
      nz_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      iter_cnt_r <= ITW'(1);
      limit_r <= CW'(255);
      for (int o = 0; o < NUM_OUTPUTS; o++) gptr_r[o] <= '0;
      for (int i = 0; i < NUM_INPUTS; i++) aptr_r[i] <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      it_r <= it_nxt;
      in_busy_r <= in_busy_nxt;
      out_busy_r <= out_busy_nxt;
      gv_r <= gv_nxt;
      nz_r <= nz_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r <= out_v_nxt;
      gptr_r <= gptr_nxt;
      aptr_r <= aptr_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_ITERATION_COUNT: iter_cnt_r <= cfg_ch.data[ITW-1:0];
          REG_QUEUE_LIMIT:     limit_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    gnt_r <= gnt_nxt;
    q_r <= q_nxt;
    eq_in_r <= eq_in_nxt;
    eq_out_r <= eq_out_nxt;
    eq_pr_r <= eq_pr_nxt;
    mi_r <= mi_nxt;
    mo_r <= mo_nxt;
    sp_r <= sp_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
  end

  // Counter memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[q_r] <= mem_wd;
    rd_r <= mem[rd_addr];
  end

  // Checks
  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC) |-> nz_r[q_r])
    else $error("decrement of an empty queue counter");

  a_busy_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_busy_r) == $countones(out_busy_r))
    else $error("matched inputs and outputs differ in number");

  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status == ST_NOMATCH) |-> out_r.last)
    else $error("no-match result without last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_IDLE) && !out_v_r)
    else $error("sequencer not idle after reset");

endmodule
